// ----- hdl/wildcard_pattern_matcher_macros.svh -----
// assertion macros shared by the wildcard pattern matcher
`ifndef WILDCARD_PATTERN_MATCHER_MACROS_SVH
`define WILDCARD_PATTERN_MATCHER_MACROS_SVH

// same-cycle implication, checked out of reset
`define WPM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define WPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/wpm_pkg.sv -----
// shared constants, types and helpers of the wildcard pattern matcher
package wpm_pkg;

    localparam int MAX_PATTERN   = 32;
    localparam int CHAR_BITS     = 16;
    localparam int POS_COUNT     = MAX_PATTERN + 1;
    localparam int LEN_BITS      = $clog2(POS_COUNT);
    localparam int IDX_BITS      = $clog2(MAX_PATTERN);
    localparam int PREFIX_LEVELS = $clog2(POS_COUNT);

    typedef logic [CHAR_BITS-1:0] char_t;
    typedef logic [1:0]           op_t;

    localparam op_t OP_LOAD   = 2'd0;
    localparam op_t OP_SAMPLE = 2'd1;
    localparam op_t OP_END    = 2'd2;

    localparam char_t STAR_CODE  = char_t'(8'h2A);
    localparam char_t QUERY_CODE = char_t'(8'h3F);
    localparam char_t UPPER_A    = char_t'(8'h41);
    localparam char_t UPPER_Z    = char_t'(8'h5A);
    localparam char_t CASE_DELTA = char_t'(8'h20);

    // control broadcast to every cell
    typedef struct packed {
        logic  step;
        logic  clear;
        char_t fc;
        char_t wr_data;
    } cell_ctrl_t;

    // status returned by one cell
    typedef struct packed {
        logic active;
        logic star;
        logic feq;
        logic adv;
    } cell_stat_t;

    function automatic char_t fold_case(input char_t c);
        if (c >= UPPER_A && c <= UPPER_Z) begin
            return c + CASE_DELTA;
        end
        return c;
    endfunction

endpackage

// ----- hdl/wildcard_pattern_matcher.sv -----
// top level of the case-insensitive wildcard pattern matcher
//
// usage
//   input channel (s_valid/s_ready) carries one item per handshake: s_op selects
//   load of a pattern character at s_pattern_index, one sample character, or
//   end of sample. only end of sample produces a result item.
//   result channel (m_valid/m_ready) carries m_matched and m_exact.
//   cfg_wr_en/cfg_wr_data write the pattern length.
// timing
//   one item per cycle sustained while s_ready is high; every op completes in
//   the cycle it is accepted because the position update is done by the row
//   of cells in parallel and the star closure is a six-level prefix network.
//   the verdict goes to the output register, or to the skid entry on a stall.
// reset
//   synchronous, active low: pattern length zero, only position zero active,
//   literal compare armed, no result pending. pattern characters are not cleared.
// stall
//   an output register plus one skid entry absorb results; s_ready drops only
//   while the skid entry is occupied, so a receiver stall holds the input
//   only once a second result is waiting.
`include "wildcard_pattern_matcher_macros.svh"

module wildcard_pattern_matcher (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [5:0]                        cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_op,
    input  logic [4:0]                        s_pattern_index,
    input  logic [15:0]                       s_char_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_matched,
    output logic                              m_exact
);

    localparam int NP = wpm_pkg::MAX_PATTERN;
    localparam int LB = wpm_pkg::LEN_BITS;
    localparam int IB = wpm_pkg::IDX_BITS;

    // configuration and sample state
    logic [LB-1:0] pattern_length_reg;
    logic [LB-1:0] sample_pos_reg;
    logic [LB-1:0] sample_pos_next;
    logic          lit_reg;
    logic          lit_next;
    logic          last_active_reg;
    logic          last_active_next;

    // output register and skid entry
    logic m_valid_reg, m_valid_next;
    logic m_matched_reg, m_exact_reg;
    logic skid_valid_reg, skid_valid_next;
    logic skid_matched_reg, skid_exact_reg;

    logic accept, load_fire, step_fire, end_fire;
    logic [LB-1:0] len_used;
    wpm_pkg::cell_ctrl_t ctrl;
    wpm_pkg::cell_stat_t stat [NP];
    logic [NP-1:0] in_use;
    logic [NP-1:0] prop;
    logic [NP-1:0] feq_vec;
    logic [wpm_pkg::POS_COUNT-1:0] active_vec;
    logic [wpm_pkg::POS_COUNT-1:0] closed;
    logic lit_hit;
    logic res_exact, res_matched;

    // handshake and op decode
    assign s_ready   = ~skid_valid_reg;
    assign accept    = s_valid & s_ready;
    assign load_fire = accept & (s_op == wpm_pkg::OP_LOAD);
    assign step_fire = accept & (s_op == wpm_pkg::OP_SAMPLE);
    assign end_fire  = accept & (s_op == wpm_pkg::OP_END);

    // length saturates at table depth
    assign len_used = (pattern_length_reg > LB'(NP)) ? LB'(NP) : pattern_length_reg;

    assign ctrl.step    = step_fire;
    assign ctrl.clear   = end_fire;
    assign ctrl.fc      = wpm_pkg::fold_case(s_char_value[wpm_pkg::CHAR_BITS-1:0]);
    assign ctrl.wr_data = s_char_value[wpm_pkg::CHAR_BITS-1:0];

    // row of cells, each passes its advance bit to the next position
    for (genvar i = 0; i < NP; i++) begin : g_cell
        assign in_use[i]     = (LB'(i) < len_used);
        assign prop[i]       = stat[i].star & in_use[i];
        assign feq_vec[i]    = stat[i].feq;
        assign active_vec[i] = stat[i].active;

        wpm_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .wr_en   (load_fire && (s_pattern_index == IB'(i))),
            .home    ((i == 0) ? 1'b1 : 1'b0),
            .in_use  (in_use[i]),
            .c_in    (closed[i]),
            .adv_in  ((i == 0) ? 1'b0 : stat[(i == 0) ? 0 : i - 1].adv),
            .stat    (stat[i])
        );
    end

    // final position has no character, only an active bit
    assign active_vec[NP] = last_active_reg;

    wpm_closure u_closure (
        .active (active_vec),
        .prop   (prop),
        .closed (closed)
    );

    // literal compare follows the sample position through the pattern
    assign lit_hit = (sample_pos_reg < len_used) && feq_vec[sample_pos_reg[IB-1:0]];

    // verdict from the state before this end item
    assign res_exact   = lit_reg && (sample_pos_reg == len_used);
    assign res_matched = closed[len_used] || res_exact;

    always_comb begin
        sample_pos_next  = sample_pos_reg;
        lit_next         = lit_reg;
        last_active_next = last_active_reg;
        if (end_fire) begin
            sample_pos_next  = '0;
            lit_next         = 1'b1;
            last_active_next = 1'b0;
        end else if (step_fire) begin
            last_active_next = stat[NP-1].adv;
            if (!lit_hit) begin
                lit_next = 1'b0;
            end
            // saturate one past the table depth
            if (sample_pos_reg < LB'(NP + 1)) begin
                sample_pos_next = sample_pos_reg + LB'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= '0;
            sample_pos_reg     <= '0;
            lit_reg            <= 1'b1;
            last_active_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                pattern_length_reg <= cfg_wr_data;
            end
            sample_pos_reg  <= sample_pos_next;
            lit_reg         <= lit_next;
            last_active_reg <= last_active_next;
        end
    end

    // output register with skid entry
    always_comb begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = end_fire;
            end
        end else if (end_fire) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_matched_reg <= skid_matched_reg;
                m_exact_reg   <= skid_exact_reg;
            end else if (end_fire) begin
                m_matched_reg <= res_matched;
                m_exact_reg   <= res_exact;
            end
        end else if (end_fire) begin
            skid_matched_reg <= res_matched;
            skid_exact_reg   <= res_exact;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_matched = m_matched_reg;
    assign m_exact   = m_exact_reg;

    `WPM_ASSERT_SAME(a_skid_needs_main, skid_valid_reg, m_valid_reg,
        "skid entry occupied while output register empty")
    `WPM_ASSERT_NEXT(a_end_gives_result, end_fire, m_valid_reg,
        "end item did not produce a result")
    `WPM_ASSERT_SAME(a_exact_implies_match, m_valid_reg, (!m_exact_reg || m_matched_reg),
        "exact verdict without match")
    `WPM_ASSERT_NEXT(a_end_clears_sample, end_fire,
        (sample_pos_reg == '0) && lit_reg && !last_active_reg,
        "sample state not cleared after end item")

endmodule

// ----- hdl/wpm_cell.sv -----
// one pattern position: stored character and its active bit
module wpm_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  wpm_pkg::cell_ctrl_t ctrl,
    input  logic                wr_en,
    input  logic                home,
    input  logic                in_use,
    input  logic                c_in,
    input  logic                adv_in,
    output wpm_pkg::cell_stat_t stat
);

    wpm_pkg::char_t char_reg;
    logic           active_reg;
    logic           active_next;
    logic           is_star;
    logic           is_query;
    logic           feq;
    logic           live;

    assign is_star  = (char_reg == wpm_pkg::STAR_CODE);
    assign is_query = (char_reg == wpm_pkg::QUERY_CODE);
    assign feq      = (wpm_pkg::fold_case(char_reg) == ctrl.fc);
    assign live     = c_in & in_use;

    always_comb begin
        active_next = active_reg;
        if (ctrl.clear) begin
            active_next = home;
        end else if (ctrl.step) begin
            // a star keeps its own position, the previous cell may advance into us
            active_next = (live & is_star) | adv_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= home;
        end else begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            char_reg <= ctrl.wr_data;
        end
    end

    assign stat.active = active_reg;
    assign stat.star   = is_star;
    assign stat.feq    = feq;
    assign stat.adv    = live & ~is_star & (is_query | feq);

endmodule

// ----- hdl/wpm_closure.sv -----
// star skip closure over the active positions as a parallel prefix
module wpm_closure (
    input  logic [wpm_pkg::POS_COUNT-1:0]   active,
    input  logic [wpm_pkg::MAX_PATTERN-1:0] prop,
    output logic [wpm_pkg::POS_COUNT-1:0]   closed
);

    logic [wpm_pkg::POS_COUNT-1:0] g [wpm_pkg::PREFIX_LEVELS+1];
    logic [wpm_pkg::POS_COUNT-1:0] p [wpm_pkg::PREFIX_LEVELS+1];

    // closed[j] = active[j] | (closed[j-1] & prop[j-1])
    always_comb begin
        g[0] = active;
        p[0] = {prop, 1'b0};
        for (int lvl = 0; lvl < wpm_pkg::PREFIX_LEVELS; lvl++) begin
            for (int j = 0; j < wpm_pkg::POS_COUNT; j++) begin
                if (j >= (1 << lvl)) begin
                    g[lvl+1][j] = g[lvl][j] | (p[lvl][j] & g[lvl][j - (1 << lvl)]);
                    p[lvl+1][j] = p[lvl][j] & p[lvl][j - (1 << lvl)];
                end else begin
                    g[lvl+1][j] = g[lvl][j];
                    p[lvl+1][j] = p[lvl][j];
                end
            end
        end
    end

    assign closed = g[wpm_pkg::PREFIX_LEVELS];

endmodule

// ----- tb/wildcard_pattern_matcher_tb.sv -----
// self-checking testbench of the wildcard pattern matcher: random stream, bit-true predictor
module wildcard_pattern_matcher_tb;

    localparam int NPOS = wpm_pkg::POS_COUNT;

    // op code the block leaves unused
    localparam wpm_pkg::op_t   OP_UNUSED = 2'd3;
    localparam wpm_pkg::char_t LOWER_A   = wpm_pkg::UPPER_A + wpm_pkg::CASE_DELTA;
    localparam wpm_pkg::char_t LOWER_Z   = wpm_pkg::UPPER_Z + wpm_pkg::CASE_DELTA;

    typedef struct {
        wpm_pkg::op_t   op;
        logic [4:0]     idx;
        wpm_pkg::char_t ch;
    } item_t;

    typedef struct packed {
        logic matched;
        logic exact;
    } verdict_t;

    // dut ports, all known from time zero
    logic           aclk;
    logic           aresetn = 1'b0;
    logic           cfg_wr_en = 1'b0;
    logic [5:0]     cfg_wr_data = '0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    wpm_pkg::op_t   s_op = wpm_pkg::OP_LOAD;
    logic [4:0]     s_pattern_index = '0;
    wpm_pkg::char_t s_char_value = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    logic           m_matched;
    logic           m_exact;

    // stimulus side
    item_t          pend_q[$];
    wpm_pkg::char_t plan_tbl[wpm_pkg::MAX_PATTERN];
    int             item_total = 0;
    int             send_gap = 0;
    int             send_quiet = 0;
    bit             sender_eager = 1'b0;

    // receiver side
    bit          squeeze_req = 1'b0;
    bit          squeeze_done = 1'b0;
    int          hold_left = 0;
    int          recv_quiet = 0;

    // predicted matcher state, updated on every accepted item
    wpm_pkg::char_t       pat_tbl[wpm_pkg::MAX_PATTERN];
    logic [5:0]           model_len = '0;
    logic [NPOS-1:0]      active_pos = NPOS'(1);
    int                   samp_pos = 0;
    bit                   literal_ok = 1'b1;
    verdict_t             verdict_q[$];
    int                   mismatch_count = 0;

    wildcard_pattern_matcher dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_pattern_index (s_pattern_index),
        .s_char_value    (s_char_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_matched       (m_matched),
        .m_exact         (m_exact)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // ascii-only case folding
    function automatic wpm_pkg::char_t lower_ascii(input wpm_pkg::char_t c);
        if (c >= wpm_pkg::UPPER_A && c <= wpm_pkg::UPPER_Z) begin
            return c + wpm_pkg::CASE_DELTA;
        end
        return c;
    endfunction

    // an active position sitting on a star also activates the one after it
    function automatic logic [NPOS-1:0] star_closure(input logic [NPOS-1:0] a,
                                                     input int n);
        logic [NPOS-1:0] c;
        c = a;
        for (int i = 0; i < n; i++) begin
            if (c[i] && pat_tbl[i] == wpm_pkg::STAR_CODE) begin
                c[i+1] = 1'b1;
            end
        end
        return c;
    endfunction

    task automatic apply_item(input wpm_pkg::op_t op, input logic [4:0] idx,
                              input wpm_pkg::char_t ch);
        logic [NPOS-1:0]      c;
        logic [NPOS-1:0]      nxt;
        wpm_pkg::char_t       fc;
        verdict_t             v;
        int                   n;
        // length register saturates at the table depth
        n = (model_len > wpm_pkg::MAX_PATTERN) ? wpm_pkg::MAX_PATTERN : int'(model_len);
        case (op)
            wpm_pkg::OP_LOAD: begin
                pat_tbl[idx] = ch;
            end
            wpm_pkg::OP_SAMPLE: begin
                fc  = lower_ascii(ch);
                c   = star_closure(active_pos, n);
                nxt = '0;
                for (int i = 0; i < n; i++) begin
                    if (c[i]) begin
                        if (pat_tbl[i] == wpm_pkg::STAR_CODE) begin
                            nxt[i] = 1'b1;
                        end else if (pat_tbl[i] == wpm_pkg::QUERY_CODE ||
                                     lower_ascii(pat_tbl[i]) == fc) begin
                            nxt[i+1] = 1'b1;
                        end
                    end
                end
                active_pos = nxt;
                // literal compare takes wildcards as plain characters
                if (!(samp_pos < n && lower_ascii(pat_tbl[samp_pos]) == fc)) begin
                    literal_ok = 1'b0;
                end
                // position counter sticks one past the table
                if (samp_pos < NPOS) begin
                    samp_pos++;
                end
            end
            wpm_pkg::OP_END: begin
                c         = star_closure(active_pos, n);
                v.exact   = literal_ok && (samp_pos == n);
                v.matched = c[n] || v.exact;
                verdict_q.insert(verdict_q.size(), v);
                active_pos = NPOS'(1);
                samp_pos   = 0;
                literal_ok = 1'b1;
            end
            default: begin
                // unused op: no state change, no verdict
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // driver: offers the pending items, random gaps after each one
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        if (sender_eager) begin
            return 0;
        end
        if (send_quiet > 0) begin
            send_quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            send_quiet = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    always @(posedge aclk) begin : drive
        item_t nxt_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            // slot is free: either idle or the current item goes this edge
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid  <= 1'b0;
            end else if (pend_q.size() > 0) begin
                nxt_item        = pend_q.pop_front();
                s_op            <= nxt_item.op;
                s_pattern_index <= nxt_item.idx;
                s_char_value    <= nxt_item.ch;
                s_valid         <= 1'b1;
                send_gap        <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------

    function automatic int pick_stall();
        int r;
        if (recv_quiet > 0) begin
            recv_quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            recv_quiet = $urandom_range(20, 60);
            return 0;
        end
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    always @(posedge aclk) begin : receive
        int k;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (squeeze_req && !squeeze_done) begin
            // long hold so that both result slots fill and the input stalls
            squeeze_done = 1'b1;
            hold_left    = 200;
            m_ready      <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            k = pick_stall();
            if (k == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready   <= 1'b0;
                hold_left = k - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: check the verdict first, then predict from the input item
    // accepted on the same edge, so a verdict in the same cycle as its end item counts as stray
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : watch
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: stray verdict, expected none, got matched=%0b exact=%0b",
                         $time, m_matched, m_exact);
                mismatch_count++;
            end else begin
                want = verdict_q.pop_front();
                if (m_matched !== want.matched) begin
                    $display("%0t: matched expected %0b, got %0b",
                             $time, want.matched, m_matched);
                    mismatch_count++;
                end
                if (m_exact !== want.exact) begin
                    $display("%0t: exact expected %0b, got %0b",
                             $time, want.exact, m_exact);
                    mismatch_count++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            apply_item(s_op, s_pattern_index, s_char_value);
        end
    end

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------

    task automatic push_item(input wpm_pkg::op_t op, input logic [4:0] idx,
                             input wpm_pkg::char_t ch);
        item_t it;
        it.op  = op;
        it.idx = idx;
        it.ch  = ch;
        pend_q.insert(pend_q.size(), it);
        // generator keeps its own view of the table for building samples
        if (op == wpm_pkg::OP_LOAD) begin
            plan_tbl[idx] = ch;
        end
        if (op != OP_UNUSED) begin
            item_total++;
        end
    endtask

    // small alphabet for frequent hits, folding edges, and full 16-bit noise
    function automatic wpm_pkg::char_t pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return LOWER_A + wpm_pkg::char_t'($urandom_range(0, 4));
        if (r < 65) return wpm_pkg::UPPER_A + wpm_pkg::char_t'($urandom_range(0, 4));
        if (r < 77) return wpm_pkg::char_t'($urandom_range(16'h20, 16'h7E));
        if (r < 89) return wpm_pkg::char_t'($urandom_range(0, 16'hFFFF));
        case ($urandom_range(0, 7))
            0: return wpm_pkg::UPPER_A - 1'b1;
            1: return wpm_pkg::UPPER_Z + 1'b1;
            2: return LOWER_A - 1'b1;
            3: return LOWER_Z + 1'b1;
            4: return wpm_pkg::UPPER_Z;
            5: return LOWER_Z;
            6: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic wpm_pkg::char_t pick_pattern_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return wpm_pkg::STAR_CODE;
        if (r < 35) return wpm_pkg::QUERY_CODE;
        return pick_char();
    endfunction

    // flip the case of a letter half of the time
    function automatic wpm_pkg::char_t twist_case(input wpm_pkg::char_t c);
        if ($urandom_range(0, 1) == 0) return c;
        if (c >= wpm_pkg::UPPER_A && c <= wpm_pkg::UPPER_Z) return c + wpm_pkg::CASE_DELTA;
        if (c >= LOWER_A && c <= LOWER_Z) return c - wpm_pkg::CASE_DELTA;
        return c;
    endfunction

    // sample given as text, optionally closed by an end item
    task automatic push_word(input string s, input bit close);
        for (int i = 0; i < s.len(); i++) begin
            push_item(wpm_pkg::OP_SAMPLE, 5'($urandom_range(0, 31)), wpm_pkg::char_t'(s[i]));
        end
        if (close) begin
            push_item(wpm_pkg::OP_END, 5'($urandom_range(0, 31)),
                      wpm_pkg::char_t'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    // one sample: mostly built from the current pattern, some random noise
    task automatic run_sample(input int cap, input bit close);
        wpm_pkg::char_t smp[$];
        int    n;
        int    r;
        n = (model_len > wpm_pkg::MAX_PATTERN) ? wpm_pkg::MAX_PATTERN : int'(model_len);
        r = $urandom_range(0, 99);
        if (r < 75) begin
            // below 60: wildcards expanded; otherwise a literal copy for exact hits
            for (int i = 0; i < n; i++) begin
                if (r < 60 && plan_tbl[i] == wpm_pkg::STAR_CODE) begin
                    repeat ($urandom_range(0, 3)) smp.insert(smp.size(), pick_char());
                end else if (r < 60 && plan_tbl[i] == wpm_pkg::QUERY_CODE) begin
                    smp.insert(smp.size(), pick_char());
                end else begin
                    smp.insert(smp.size(), twist_case(plan_tbl[i]));
                end
            end
            // occasional single-character damage
            if ($urandom_range(0, 9) < 3) begin
                case ($urandom_range(0, 2))
                    0: if (smp.size() > 0) smp[$urandom_range(0, smp.size() - 1)] = pick_char();
                    1: smp.insert($urandom_range(0, smp.size()), pick_char());
                    default: if (smp.size() > 0) smp.delete($urandom_range(0, smp.size() - 1));
                endcase
            end
        end else if (r < 93) begin
            repeat ($urandom_range(0, n + 3)) smp.insert(smp.size(), pick_char());
        end else begin
            // up to 40 characters, can run past the table: position counter saturates
            repeat ($urandom_range(30, 40)) smp.insert(smp.size(), pick_char());
        end
        while (smp.size() > cap) void'(smp.pop_back());
        foreach (smp[i]) begin
            // pattern rewrites and unused ops in the middle of a sample
            if ($urandom_range(0, 99) < 3) begin
                push_item(wpm_pkg::OP_LOAD, 5'($urandom_range(0, 31)), pick_pattern_char());
            end
            if ($urandom_range(0, 99) < 2) begin
                push_item(OP_UNUSED, 5'($urandom_range(0, 31)),
                          wpm_pkg::char_t'($urandom_range(0, 16'hFFFF)));
            end
            push_item(wpm_pkg::OP_SAMPLE, 5'($urandom_range(0, 31)), smp[i]);
        end
        if (close) begin
            push_item(wpm_pkg::OP_END, 5'($urandom_range(0, 31)),
                      wpm_pkg::char_t'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    // wait until every item is taken and every verdict is back
    task automatic settle();
        while (pend_q.size() != 0 || s_valid || verdict_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // length register is only written with the block idle
    task automatic set_length(input logic [5:0] v);
        settle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        model_len = v;
        @(negedge aclk);
    endtask

    function automatic logic [5:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 6'd0;
        if (r < 20) return 6'd32;
        if (r < 25) return 6'd63;
        if (r < 30) return 6'($urandom_range(33, 62));
        if (r < 40) return 6'd1;
        return 6'($urandom_range(2, 10));
    endfunction

    initial begin : stimulus
        string       head;
        int          phase;
        int          n;
        logic [5:0]  len;
        head  = "a*B?c";
        phase = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // length zero after reset: the table is never read
        push_word("", 1'b1);                 // empty sample against empty pattern
        push_word("q", 1'b1);                // any character fails an empty pattern
        push_item(OP_UNUSED, 5'd31, '1);     // ignored op

        // fill the whole table so no later read hits an unwritten entry
        for (int i = 0; i < wpm_pkg::MAX_PATTERN; i++) begin
            if (i < head.len()) begin
                push_item(wpm_pkg::OP_LOAD, 5'(i), wpm_pkg::char_t'(head[i]));
            end else if (i == wpm_pkg::MAX_PATTERN - 2) begin
                push_item(wpm_pkg::OP_LOAD, 5'(i), '0);
            end else if (i == wpm_pkg::MAX_PATTERN - 1) begin
                push_item(wpm_pkg::OP_LOAD, 5'(i), '1);
            end else begin
                push_item(wpm_pkg::OP_LOAD, 5'(i), pick_pattern_char());
            end
        end

        // pattern a*B?c: star over a run, star over nothing, literal, too short
        set_length(6'd5);
        push_word("AxYbQC", 1'b1);
        push_word("abzc", 1'b1);
        push_word("A*b?C", 1'b1);
        push_word("abc", 1'b1);
        // pattern rewritten in the middle of a sample
        push_word("a", 1'b0);
        push_item(wpm_pkg::OP_LOAD, 5'd2, wpm_pkg::UPPER_Z);
        push_word("zkc", 1'b1);

        // random phases: new length, mostly a new pattern, a handful of samples
        while (item_total < 1450) begin
            phase++;
            len = pick_length();
            set_length(len);
            n = (len > wpm_pkg::MAX_PATTERN) ? wpm_pkg::MAX_PATTERN : int'(len);
            if ($urandom_range(0, 9) < 8) begin
                for (int i = 0; i < n; i++) begin
                    push_item(wpm_pkg::OP_LOAD, 5'(i), pick_pattern_char());
                end
            end
            if (phase == 3) begin
                // receiver holds off while the sender pushes short samples flat out
                sender_eager <= 1'b1;
                squeeze_req  <= 1'b1;
                repeat (40) run_sample(2, 1'b1);
                settle();
                sender_eager <= 1'b0;
            end
            repeat ($urandom_range(2, 8)) run_sample(40, 1'b1);
            // sometimes leave a sample open across the next length write
            if ($urandom_range(0, 9) == 0) begin
                run_sample(40, 1'b0);
            end
        end

        settle();
        repeat (6) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- wildcard_pattern_matcher.f -----
+incdir+hdl
hdl/wpm_pkg.sv
hdl/wpm_cell.sv
hdl/wpm_closure.sv
hdl/wildcard_pattern_matcher.sv
tb/wildcard_pattern_matcher_tb.sv
